// ----- design/tpas_pkg.sv -----
// Package for the token pipeline ALU and store core.
// Holds the channel payload types, the opcode and command codes and fixed sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpas_pkg;

   localparam int DataWidth = 32;
   localparam int RegIndexWidth = 4;
   localparam int NumRegisters = 16;
   localparam int MemAddrWidth = 4;

   typedef enum logic [1:0] {
      CMD_IDLE    = 2'd0,
      CMD_INSTR   = 2'd1,
      CMD_PRELOAD = 2'd2,
      CMD_SPARE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_ST  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_IDLE    = 2'd0,
      KIND_INSTR   = 2'd1,
      KIND_PRELOAD = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [1:0]         opcode;
      logic [3:0]         dest_reg;
      logic [3:0]         src1_reg;
      logic [3:0]         src2_reg;
      logic signed [15:0] store_offset;
      logic signed [31:0] preload_value;
   } req_type;

   typedef struct packed {
      logic               reg_write_valid;
      logic [3:0]         reg_write_index;
      logic signed [31:0] reg_write_value;
      logic               store_valid;
      logic [3:0]         store_address;
      logic signed [31:0] store_value;
      logic               address_fault;
      logic               queue_overflow;
      logic               pipeline_empty;
   } rsp_type;

   // Classified tick passed from the front to the back
   typedef struct packed {
      kind_type                 kind;
      op_type                   op;
      logic [RegIndexWidth-1:0] dest;
      logic [RegIndexWidth-1:0] src1;
      logic [RegIndexWidth-1:0] src2;
      logic [DataWidth-1:0]     operand;
   } tick_type;

endpackage
`default_nettype wire

// ----- design/tpas_front.sv -----
// Front end: classifies each incoming item into a tick for the back end.
// Depends on tpas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpas_front
   import tpas_pkg::*;
(
   input  var req_type  req_payload,
   output tick_type     tick
);

   // Decode the command and pick the literal operand
   always_comb begin
      tick = '0;
      tick.op   = op_type'(req_payload.opcode);
      tick.dest = req_payload.dest_reg;
      tick.src1 = req_payload.src1_reg;
      tick.src2 = req_payload.src2_reg;
      case (cmd_type'(req_payload.cmd))
         CMD_INSTR: begin
            tick.kind    = KIND_INSTR;
            tick.operand = DataWidth'(signed'(req_payload.store_offset));
         end
         CMD_PRELOAD: begin
            tick.kind    = KIND_PRELOAD;
            tick.operand = req_payload.preload_value;
         end
         default: begin
            tick.kind    = KIND_IDLE;
            tick.operand = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- design/tpas_queue.sv -----
// Two-entry tick queue between front and back ends.
// Depends on tpas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpas_queue
   import tpas_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          in_valid,
   output logic         in_ready,
   input  var tick_type in_tick,
   output logic         out_valid,
   input  wire          out_ready,
   output tick_type     out_tick
);

   tick_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_tick  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_tick;
      end
   end

endmodule
`default_nettype wire

// ----- design/tpas_back.sv -----
// Back end: runs one pipeline tick per non-preload item, registers results.
// Depends on tpas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpas_back
   import tpas_pkg::*;
#(
   parameter int RESULT_QUEUE_DEPTH = 4
)(
   input  wire          clock,
   input  wire          reset,
   input  wire          tick_valid,
   output logic         tick_ready,
   input  var tick_type tick,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int IW = (RESULT_QUEUE_DEPTH > 1) ? $clog2(RESULT_QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(RESULT_QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] QDepth = CW'(RESULT_QUEUE_DEPTH);

   typedef logic [DataWidth-1:0]     data_type;
   typedef logic [RegIndexWidth-1:0] ridx_type;

   // Architectural state
   data_type rf_ff [NumRegisters];

   logic     dec_valid_ff, dec_valid_in;
   op_type   dec_op_ff, dec_op_in;
   ridx_type dec_reg_ff, dec_reg_in;
   data_type dec_a_ff, dec_a_in, dec_b_ff, dec_b_in;

   logic     alu_valid_ff, alu_valid_in;
   op_type   alu_op_ff, alu_op_in;
   ridx_type alu_reg_ff, alu_reg_in;
   data_type alu_a_ff, alu_a_in, alu_b_ff, alu_b_in;

   logic     mul_valid_ff, mul_valid_in;
   ridx_type mul_reg_ff, mul_reg_in;
   data_type mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;

   logic     sis_valid_ff, sis_valid_in;
   ridx_type sis_reg_ff, sis_reg_in;
   data_type sis_a_ff, sis_a_in, sis_b_ff, sis_b_in;

   logic     asl_valid_ff, asl_valid_in;
   ridx_type asl_reg_ff, asl_reg_in;
   data_type asl_a_ff, asl_a_in;

   ridx_type        q_reg_ff [RESULT_QUEUE_DEPTH];
   data_type        q_val_ff [RESULT_QUEUE_DEPTH];
   logic [IW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;

   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;

   // Tick control
   logic          fire, run, wb;
   ridx_type      wb_reg;
   data_type      wb_val;
   logic [CW-1:0] cnt0, cnt1;
   logic          push_m, push_a, drop_m, drop_a;
   logic [IW-1:0] pos_m, pos_a;
   data_type      mul_prod, alu_res;
   logic          rf_we;
   ridx_type      rf_wa;
   data_type      rf_wd;

   function automatic logic [IW-1:0] wrap_pos(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(RESULT_QUEUE_DEPTH)) begin
         sum = sum - (CW+1)'(RESULT_QUEUE_DEPTH);
      end
      return IW'(sum);
   endfunction

   // Register read after this tick's write-back
   function automatic data_type rd_fwd(input ridx_type idx, input logic we,
                                       input ridx_type wa, input data_type wd,
                                       input data_type cur);
      return (we && wa == idx) ? wd : cur;
   endfunction

   assign tick_ready  = !rsp_valid_ff || rsp_ready;
   assign fire        = tick_valid && tick_ready;
   assign run         = fire && (tick.kind != KIND_PRELOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign wb     = (count_ff != '0);
   assign wb_reg = q_reg_ff[head_ff];
   assign wb_val = q_val_ff[head_ff];

   assign mul_prod = mul_a_ff * mul_b_ff;
   assign alu_res  = (alu_op_ff == OP_SUB) ? alu_a_ff - alu_b_ff : alu_a_ff + alu_b_ff;

   // Work out one tick of the token pipeline
   always_comb begin
      dec_valid_in = dec_valid_ff;
      dec_op_in    = dec_op_ff;
      dec_reg_in   = dec_reg_ff;
      dec_a_in     = dec_a_ff;
      dec_b_in     = dec_b_ff;
      alu_valid_in = alu_valid_ff;
      alu_op_in    = alu_op_ff;
      alu_reg_in   = alu_reg_ff;
      alu_a_in     = alu_a_ff;
      alu_b_in     = alu_b_ff;
      mul_valid_in = mul_valid_ff;
      mul_reg_in   = mul_reg_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      sis_valid_in = sis_valid_ff;
      sis_reg_in   = sis_reg_ff;
      sis_a_in     = sis_a_ff;
      sis_b_in     = sis_b_ff;
      asl_valid_in = asl_valid_ff;
      asl_reg_in   = asl_reg_ff;
      asl_a_in     = asl_a_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_in       = '0;
      rf_we        = 1'b0;
      rf_wa        = tick.dest;
      rf_wd        = tick.operand;
      push_m       = 1'b0;
      push_a       = 1'b0;
      drop_m       = 1'b0;
      drop_a       = 1'b0;
      cnt0         = count_ff;
      cnt1         = count_ff;
      pos_m        = '0;
      pos_a        = '0;

      if (fire && tick.kind == KIND_PRELOAD) begin
         rf_we = 1'b1;
      end

      if (run) begin
         // write back the queue head
         if (wb) begin
            rf_we   = 1'b1;
            rf_wa   = wb_reg;
            rf_wd   = wb_val;
            head_in = (head_ff == IW'(RESULT_QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            rsp_in.reg_write_valid = 1'b1;
            rsp_in.reg_write_index = wb_reg;
            rsp_in.reg_write_value = wb_val;
         end
         cnt0 = count_ff - CW'(wb);

         // store
         if (asl_valid_ff) begin
            rsp_in.store_valid   = 1'b1;
            rsp_in.store_address = asl_a_ff[MemAddrWidth-1:0];
            rsp_in.store_value   = rd_fwd(asl_reg_ff, wb, wb_reg, wb_val,
                                          rf_ff[asl_reg_ff]);
            rsp_in.address_fault = (asl_a_ff[DataWidth-1:MemAddrWidth] != '0);
            asl_valid_in = 1'b0;
         end

         // address add
         if (sis_valid_ff) begin
            asl_valid_in = 1'b1;
            asl_reg_in   = sis_reg_ff;
            asl_a_in     = sis_a_ff + sis_b_ff;
            sis_valid_in = 1'b0;
         end

         // store issue
         if (dec_valid_ff && dec_op_ff == OP_ST) begin
            sis_valid_in = 1'b1;
            sis_reg_in   = dec_reg_ff;
            sis_a_in     = dec_a_ff;
            sis_b_in     = dec_b_ff;
            dec_valid_in = 1'b0;
         end

         // multiply stage two: push before add/subtract
         if (mul_valid_ff) begin
            if (cnt0 < QDepth) begin
               push_m = 1'b1;
               pos_m  = wrap_pos(head_in, cnt0);
            end else begin
               drop_m = 1'b1;
            end
            mul_valid_in = 1'b0;
         end
         cnt1 = cnt0 + CW'(push_m);

         // multiply stage one
         if (alu_valid_ff && alu_op_ff == OP_MUL) begin
            mul_valid_in = 1'b1;
            mul_reg_in   = alu_reg_ff;
            mul_a_in     = alu_a_ff;
            mul_b_in     = alu_b_ff;
            alu_valid_in = 1'b0;
         end

         // add / subtract
         if (alu_valid_ff && (alu_op_ff == OP_ADD || alu_op_ff == OP_SUB)) begin
            if (cnt1 < QDepth) begin
               push_a = 1'b1;
               pos_a  = wrap_pos(head_in, cnt1);
            end else begin
               drop_a = 1'b1;
            end
            alu_valid_in = 1'b0;
         end
         count_in = cnt1 + CW'(push_a);

         // ALU issue
         if (dec_valid_ff && dec_op_ff != OP_ST) begin
            alu_valid_in = 1'b1;
            alu_op_in    = dec_op_ff;
            alu_reg_in   = dec_reg_ff;
            alu_a_in     = dec_a_ff;
            alu_b_in     = dec_b_ff;
            dec_valid_in = 1'b0;
         end

         // decode the new instruction
         if (tick.kind == KIND_INSTR) begin
            dec_valid_in = 1'b1;
            dec_op_in    = tick.op;
            dec_reg_in   = tick.dest;
            dec_a_in     = rd_fwd(tick.src1, wb, wb_reg, wb_val, rf_ff[tick.src1]);
            dec_b_in     = (tick.op == OP_ST) ? tick.operand :
                           rd_fwd(tick.src2, wb, wb_reg, wb_val, rf_ff[tick.src2]);
         end

         rsp_in.queue_overflow = drop_m || drop_a;
         rsp_in.pipeline_empty = !dec_valid_in && !alu_valid_in && !mul_valid_in &&
                                 !sis_valid_in && !asl_valid_in && (count_in == '0);
      end else begin
         rsp_in.pipeline_empty = !dec_valid_ff && !alu_valid_ff && !mul_valid_ff &&
                                 !sis_valid_ff && !asl_valid_ff && (count_ff == '0);
      end
   end

   // Output register: load on a tick, clear when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
         alu_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         sis_valid_ff <= 1'b0;
         asl_valid_ff <= 1'b0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dec_valid_ff <= dec_valid_in;
         alu_valid_ff <= alu_valid_in;
         mul_valid_ff <= mul_valid_in;
         sis_valid_ff <= sis_valid_in;
         asl_valid_ff <= asl_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Slot payloads
   always_ff @(posedge clock) begin
      dec_op_ff  <= dec_op_in;
      dec_reg_ff <= dec_reg_in;
      dec_a_ff   <= dec_a_in;
      dec_b_ff   <= dec_b_in;
      alu_op_ff  <= alu_op_in;
      alu_reg_ff <= alu_reg_in;
      alu_a_ff   <= alu_a_in;
      alu_b_ff   <= alu_b_in;
      mul_reg_ff <= mul_reg_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      sis_reg_ff <= sis_reg_in;
      sis_a_ff   <= sis_a_in;
      sis_b_ff   <= sis_b_in;
      asl_reg_ff <= asl_reg_in;
      asl_a_ff   <= asl_a_in;
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // Result queue entries
   always_ff @(posedge clock) begin
      if (push_m) begin
         q_reg_ff[pos_m] <= mul_reg_ff;
         q_val_ff[pos_m] <= mul_prod;
      end
      if (push_a) begin
         q_reg_ff[pos_a] <= alu_reg_ff;
         q_val_ff[pos_a] <= alu_res;
      end
   end

   // Register file: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegisters; i++) begin
            rf_ff[i] <= '0;
         end
      end else if (rf_we) begin
         rf_ff[rf_wa] <= rf_wd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QDepth)
      else $error("result queue count beyond depth");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      run && (drop_m || drop_a) |-> count_in == QDepth)
      else $error("result dropped while queue had room");

   a_decode_fill: assert property (@(posedge clock) disable iff (reset)
      run && tick.kind == KIND_INSTR |=> dec_valid_ff)
      else $error("decode slot not filled by instruction");

   a_store_fires: assert property (@(posedge clock) disable iff (reset)
      run && asl_valid_ff |=> rsp_ff.store_valid)
      else $error("pending store not reported");

endmodule
`default_nettype wire

// ----- design/token_pipeline_alu_store_core_unit.sv -----
// Token pipeline ALU and store core: one pipeline tick per accepted non-preload item.
// Path: item accepted, tick queue, then output register before the result is shown.
// Throughput: one item, one back end tick per cycle, unless a result waits untaken.
// Reset: synchronous, clears registers, pipeline slots, result queue count, queues.
// Depends on tpas_pkg, tpas_front, tpas_queue, tpas_back.
`timescale 1ns / 1ps
`default_nettype none
module token_pipeline_alu_store_core_unit
   import tpas_pkg::*;
#(
   parameter int RESULT_QUEUE_DEPTH = 4
)(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  var req_type req_payload,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output rsp_type     rsp_payload
);

   tick_type front_tick, back_tick;
   logic     back_valid, back_ready;

   tpas_front u_front (
      .req_payload (req_payload),
      .tick        (front_tick)
   );

   tpas_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_tick   (front_tick),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_tick  (back_tick)
   );

   tpas_back #(
      .RESULT_QUEUE_DEPTH (RESULT_QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .tick_valid  (back_valid),
      .tick_ready  (back_ready),
      .tick        (back_tick),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- dv/tb_token_pipeline_alu_store_core_unit.sv -----
// Testbench for the token pipeline ALU and store core: drives ticks, checks each result item.
// Holds its own pipeline predictor, a queue-fed driver and a monitor.
// Depends on tpas_pkg and token_pipeline_alu_store_core_unit.
`timescale 1ns / 1ps
module tb_token_pipeline_alu_store_core_unit;
   import tpas_pkg::*;

   localparam int QueueDepth = 4;
   localparam int MemWords = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;

   token_pipeline_alu_store_core_unit #(.RESULT_QUEUE_DEPTH(QueueDepth)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state
   typedef struct {
      bit          valid;
      logic [1:0]  op;
      logic [3:0]  dest;
      logic [31:0] a;
      logic [31:0] b;
   } stage_slot_type;

   logic [31:0]    gpr [16];
   stage_slot_type dec_s, alu_s, mul_s, sti_s, adr_s;
   logic [3:0]     wbq_reg [QueueDepth];
   logic [31:0]    wbq_val [QueueDepth];
   int             wbq_head, wbq_count;

   req_type pending_items[$];
   rsp_type expected_rsp[$];
   int      fail_count = 0;
   int      sender_idle_pct = 0;
   int      receiver_stall_pct = 0;

   function automatic bit wbq_push(logic [3:0] r, logic [31:0] v);
      if (wbq_count >= QueueDepth) return 1'b0;
      wbq_reg[(wbq_head + wbq_count) % QueueDepth] = r;
      wbq_val[(wbq_head + wbq_count) % QueueDepth] = v;
      wbq_count++;
      return 1'b1;
   endfunction

   function automatic bit pipe_drained();
      return !dec_s.valid && !alu_s.valid && !mul_s.valid && !sti_s.valid &&
         !adr_s.valid && wbq_count == 0;
   endfunction

   // Advance the predictor by one tick and return the result item
   function automatic rsp_type predict_tick(req_type it);
      rsp_type r;
      logic [31:0] addr;
      r = '0;
      if (it.cmd == CMD_PRELOAD) begin
         gpr[it.dest_reg] = it.preload_value;
         r.pipeline_empty = pipe_drained();
         return r;
      end
      if (wbq_count > 0) begin
         gpr[wbq_reg[wbq_head]] = wbq_val[wbq_head];
         r.reg_write_valid = 1'b1;
         r.reg_write_index = wbq_reg[wbq_head];
         r.reg_write_value = wbq_val[wbq_head];
         wbq_head = (wbq_head + 1) % QueueDepth;
         wbq_count--;
      end
      if (adr_s.valid) begin
         addr = adr_s.a;
         r.store_valid = 1'b1;
         r.store_address = 4'(addr % MemWords);
         r.store_value = gpr[adr_s.dest];
         r.address_fault = addr[31] || addr >= MemWords;
         adr_s.valid = 1'b0;
      end
      if (sti_s.valid) begin
         adr_s = sti_s;
         adr_s.a = sti_s.a + sti_s.b;
         sti_s.valid = 1'b0;
      end
      if (dec_s.valid && dec_s.op == OP_ST) begin
         sti_s = dec_s;
         dec_s.valid = 1'b0;
      end
      if (mul_s.valid) begin
         if (!wbq_push(mul_s.dest, mul_s.a * mul_s.b)) r.queue_overflow = 1'b1;
         mul_s.valid = 1'b0;
      end
      if (alu_s.valid && alu_s.op == OP_MUL) begin
         mul_s = alu_s;
         alu_s.valid = 1'b0;
      end
      if (alu_s.valid && (alu_s.op == OP_ADD || alu_s.op == OP_SUB)) begin
         if (!wbq_push(alu_s.dest, alu_s.op == OP_ADD ? alu_s.a + alu_s.b
               : alu_s.a - alu_s.b)) r.queue_overflow = 1'b1;
         alu_s.valid = 1'b0;
      end
      if (dec_s.valid && dec_s.op != OP_ST) begin
         alu_s = dec_s;
         dec_s.valid = 1'b0;
      end
      if (it.cmd == CMD_INSTR) begin
         dec_s.valid = 1'b1;
         dec_s.op = it.opcode;
         dec_s.dest = it.dest_reg;
         dec_s.a = gpr[it.src1_reg];
         dec_s.b = (it.opcode == OP_ST) ? 32'(it.store_offset) : gpr[it.src2_reg];
      end
      r.pipeline_empty = pipe_drained();
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Driver: present items at the falling edge, hold until accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_ready) begin
            // hold
         end else if (pending_items.size() > 0 &&
               $urandom_range(99, 0) >= sender_idle_pct) begin
            req_payload <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
         rsp_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
      end
   end

   // Monitor: predict on accepted items, check on accepted results
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset) begin
         if (req_valid && req_ready) expected_rsp.push_back(predict_tick(req_payload));
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected item", 64'(got), 64'd0);
            end else begin
               want = expected_rsp.pop_front();
               if (got.reg_write_valid !== want.reg_write_valid)
                  report_mismatch("reg_write_valid", 64'(got.reg_write_valid),
                     64'(want.reg_write_valid));
               if (got.reg_write_index !== want.reg_write_index)
                  report_mismatch("reg_write_index", 64'(got.reg_write_index),
                     64'(want.reg_write_index));
               if (got.reg_write_value !== want.reg_write_value)
                  report_mismatch("reg_write_value", 64'(unsigned'(got.reg_write_value)),
                     64'(unsigned'(want.reg_write_value)));
               if (got.store_valid !== want.store_valid)
                  report_mismatch("store_valid", 64'(got.store_valid),
                     64'(want.store_valid));
               if (got.store_address !== want.store_address)
                  report_mismatch("store_address", 64'(got.store_address),
                     64'(want.store_address));
               if (got.store_value !== want.store_value)
                  report_mismatch("store_value", 64'(unsigned'(got.store_value)),
                     64'(unsigned'(want.store_value)));
               if (got.address_fault !== want.address_fault)
                  report_mismatch("address_fault", 64'(got.address_fault),
                     64'(want.address_fault));
               if (got.queue_overflow !== want.queue_overflow)
                  report_mismatch("queue_overflow", 64'(got.queue_overflow),
                     64'(want.queue_overflow));
               if (got.pipeline_empty !== want.pipeline_empty)
                  report_mismatch("pipeline_empty", 64'(got.pipeline_empty),
                     64'(want.pipeline_empty));
            end
         end
      end
   end

   function automatic req_type make_item(cmd_type c, op_type o, int rd, int rs1, int rs2,
         logic [15:0] off, logic [31:0] pre);
      req_type it;
      it.cmd = c;
      it.opcode = o;
      it.dest_reg = 4'(rd);
      it.src1_reg = 4'(rs1);
      it.src2_reg = 4'(rs2);
      it.store_offset = off;
      it.preload_value = pre;
      return it;
   endfunction

   function automatic req_type random_item();
      req_type it;
      int pick;
      it = req_type'({$urandom, $urandom});
      pick = $urandom_range(99, 0);
      // Mostly instructions, some preloads, a little idle and spare
      if (pick < 65) it.cmd = CMD_INSTR;
      else if (pick < 80) it.cmd = CMD_PRELOAD;
      else if (pick < 92) it.cmd = CMD_IDLE;
      else it.cmd = CMD_SPARE;
      // Keep store addresses mostly in range
      if (it.opcode == OP_ST && $urandom_range(3, 0) != 0)
         it.store_offset = 16'($urandom_range(15, 0));
      if (it.cmd == CMD_PRELOAD && $urandom_range(2, 0) == 0)
         it.preload_value = $urandom_range(20, 0) - 4;
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
   endtask

   // Stimulus
   initial begin
      dec_s = '{default: '0}; alu_s = dec_s; mul_s = dec_s; sti_s = dec_s; adr_s = dec_s;
      foreach (gpr[i]) gpr[i] = '0;
      wbq_head = 0;
      wbq_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every opcode, faults, spare command
      pending_items.push_back(make_item(CMD_PRELOAD, OP_ADD, 1, 0, 0, 0, 32'h7fffffff));
      pending_items.push_back(make_item(CMD_PRELOAD, OP_ADD, 2, 0, 0, 0, 32'h80000000));
      pending_items.push_back(make_item(CMD_PRELOAD, OP_ADD, 15, 0, 0, 0, 32'hffffffff));
      pending_items.push_back(make_item(CMD_PRELOAD, OP_ADD, 3, 0, 0, 0, 32'd5));
      pending_items.push_back(make_item(CMD_INSTR, OP_ADD, 4, 1, 1, 0, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_SUB, 5, 2, 1, 0, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_MUL, 6, 15, 2, 0, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_ADD, 7, 3, 3, 0, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_MUL, 8, 1, 1, 0, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_SUB, 9, 3, 15, 0, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_ADD, 10, 3, 3, 0, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_ADD, 11, 3, 3, 0, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_ST, 1, 3, 0, 16'sd3, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_ST, 2, 3, 0, 16'h8000, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_ST, 15, 0, 0, 16'h7fff, 0));
      pending_items.push_back(make_item(CMD_INSTR, OP_ST, 3, 3, 0, 16'hffff, 0));
      pending_items.push_back(make_item(CMD_SPARE, OP_ST, 15, 15, 15, 16'hffff, 32'hffffffff));
      repeat (6) pending_items.push_back(make_item(CMD_IDLE, OP_ADD, 0, 0, 0, 0, 0));
      wait_drained();

      // Random phases with different idling
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
            3: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
            default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
         endcase
         repeat (150) pending_items.push_back(random_item());
         wait_drained();
      end
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Run limit
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

// ----- files.f -----
design/tpas_pkg.sv
design/tpas_front.sv
design/tpas_queue.sv
design/tpas_back.sv
design/token_pipeline_alu_store_core_unit.sv
dv/tb_token_pipeline_alu_store_core_unit.sv
